[rtl/taabb_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, types and helpers for the transformed box pipeline.
// Used by taabb_lane and transformed_aabb; depends on nothing else.
package taabb_pkg;

  localparam int COORD_W = 32;   // signed fixed-point coordinate
  localparam int HALF_W  = 31;   // unsigned half extent
  localparam int PROD_W  = 64;   // full 32x32 signed product
  localparam int SUM_W   = 67;   // exact sum of three products plus translation
  localparam int IN_W    = 576;  // input word, padded to whole bytes
  localparam int OUT_W   = 192;  // result word, padded to whole bytes

  typedef logic signed [COORD_W-1:0] coord_t;

  // Stage enables handed from the pipeline control to each axis lane.
  typedef struct packed {
    logic prod;
    logic sum;
    logic sat;
  } lane_en_t;

  // Saturate a 33-bit signed value to the 32-bit coordinate range.
  function automatic coord_t sat_corner(input logic signed [COORD_W:0] v);
    coord_t r;
    if (v[COORD_W] == v[COORD_W-1]) begin
      r = v[COORD_W-1:0];
    end else if (v[COORD_W]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

[rtl/taabb_lane.sv]
`timescale 1ns / 1ps
// One output axis: bounds of a transformed coordinate over all box corners.
// Depends on taabb_pkg; instantiated three times by transformed_aabb.
module taabb_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  taabb_pkg::lane_en_t en,
  input  taabb_pkg::coord_t  lo [3],
  input  taabb_pkg::coord_t  hi [3],
  input  taabb_pkg::coord_t  m [3],
  input  taabb_pkg::coord_t  m3,
  output taabb_pkg::coord_t  vmin,
  output taabb_pkg::coord_t  vmax
);
  import taabb_pkg::*;

  // The corners form a full product of per-axis choices, so the extreme
  // sum takes, per column, the smaller or larger of the two products.
  // Floor shift and saturation are monotone, so they follow afterwards.
  coord_t                    sel_min [3];
  coord_t                    sel_max [3];
  logic signed [PROD_W-1:0]  pmin_c [3];
  logic signed [PROD_W-1:0]  pmax_c [3];
  logic signed [PROD_W-1:0]  pmin [3];
  logic signed [PROD_W-1:0]  pmax [3];
  coord_t                    trans;
  logic signed [SUM_W-1:0]   tshift;
  logic signed [SUM_W-1:0]   smin;
  logic signed [SUM_W-1:0]   smax;
  logic signed [SUM_W-1:0]   shmin;
  logic signed [SUM_W-1:0]   shmax;

  // Operand selection by the sign of the matrix entry, one multiplier pair per column.
  for (genvar i = 0; i < 3; i++) begin : g_col
    assign sel_min[i] = m[i][COORD_W-1] ? hi[i] : lo[i];
    assign sel_max[i] = m[i][COORD_W-1] ? lo[i] : hi[i];
    assign pmin_c[i]  = m[i] * sel_min[i];
    assign pmax_c[i]  = m[i] * sel_max[i];
  end

  // Product stage.
  always_ff @(posedge clk) begin
    if (en.prod) begin
      pmin  <= pmin_c;
      pmax  <= pmax_c;
      trans <= m3;
    end
  end

  assign tshift = SUM_W'(trans) <<< FRAC_BITS;

  // Exact sum stage.
  always_ff @(posedge clk) begin
    if (en.sum) begin
      smin <= SUM_W'(pmin[0]) + SUM_W'(pmin[1]) + SUM_W'(pmin[2]) + tshift;
      smax <= SUM_W'(pmax[0]) + SUM_W'(pmax[1]) + SUM_W'(pmax[2]) + tshift;
    end
  end

  assign shmin = smin >>> FRAC_BITS;
  assign shmax = smax >>> FRAC_BITS;

  function automatic coord_t sat_sum(input logic signed [SUM_W-1:0] v);
    coord_t r;
    if (v[SUM_W-1:COORD_W-1] == '0 || v[SUM_W-1:COORD_W-1] == '1) begin
      r = v[COORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Scale back to fixed point and saturate.
  always_ff @(posedge clk) begin
    if (en.sat) begin
      vmin <= sat_sum(shmin);
      vmax <= sat_sum(shmax);
    end
  end

endmodule

[rtl/transformed_aabb.sv]
`timescale 1ns / 1ps
// Transformed axis-aligned box: center and half extent through an affine matrix.
// Depends on taabb_pkg and three instances of taabb_lane.
// A result word passes the input capture, corner, product, sum, saturate and result registers.
// Throughput: one word per cycle, set by 18 parallel 32x32 multipliers in
// the product stage; stages hold their data under backpressure.
// Reset clears every stage valid bit; data registers are not reset.
module transformed_aabb #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // box_center_x, box_center_y, box_center_z, box_half_x, box_half_y, box_half_z,
  // row0_cols01, row0_cols23, row1_cols01, row1_cols23, row2_cols01, row2_cols23
  input  logic [taabb_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_center_x, out_center_y, out_center_z, out_half_x, out_half_y, out_half_z
  output logic [taabb_pkg::OUT_W-1:0]    m_axis_tdata
);
  import taabb_pkg::*;

  // Stage valid bits and enables; a stage loads when empty or when draining.
  logic v1, v2, v3, v4, v5, vout;
  logic en1, en2, en_out;
  lane_en_t lane_en;

  assign en_out       = !vout || m_axis_tready;
  assign lane_en.sat  = !v5 || en_out;
  assign lane_en.sum  = !v4 || lane_en.sat;
  assign lane_en.prod = !v3 || lane_en.sum;
  assign en2          = !v2 || lane_en.prod;
  assign en1          = !v1 || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      vout <= 1'b0;
    end else begin
      if (en1)          v1   <= s_axis_tvalid;
      if (en2)          v2   <= v1;
      if (lane_en.prod) v3   <= v2;
      if (lane_en.sum)  v4   <= v3;
      if (lane_en.sat)  v5   <= v4;
      if (en_out)       vout <= v5;
    end
  end

  // Input capture stage.
  coord_t                   ctr1 [3];
  logic [HALF_W-1:0]        half1 [3];
  coord_t                   mat1 [3][4];

  always_ff @(posedge clk) begin
    if (en1) begin
      ctr1[0]  <= s_axis_tdata[31:0];
      ctr1[1]  <= s_axis_tdata[63:32];
      ctr1[2]  <= s_axis_tdata[95:64];
      half1[0] <= s_axis_tdata[126:96];
      half1[1] <= s_axis_tdata[157:127];
      half1[2] <= s_axis_tdata[188:158];
      mat1[0][0] <= s_axis_tdata[220:189];
      mat1[0][1] <= s_axis_tdata[252:221];
      mat1[0][2] <= s_axis_tdata[284:253];
      mat1[0][3] <= s_axis_tdata[316:285];
      mat1[1][0] <= s_axis_tdata[348:317];
      mat1[1][1] <= s_axis_tdata[380:349];
      mat1[1][2] <= s_axis_tdata[412:381];
      mat1[1][3] <= s_axis_tdata[444:413];
      mat1[2][0] <= s_axis_tdata[476:445];
      mat1[2][1] <= s_axis_tdata[508:477];
      mat1[2][2] <= s_axis_tdata[540:509];
      mat1[2][3] <= s_axis_tdata[572:541];
    end
  end

  // Corner bounds per local axis, saturated to the coordinate range.
  logic signed [COORD_W:0]  lo_ext [3];
  logic signed [COORD_W:0]  hi_ext [3];
  coord_t                   lo2 [3];
  coord_t                   hi2 [3];
  coord_t                   mat2 [3][4];

  for (genvar a = 0; a < 3; a++) begin : g_corner
    assign lo_ext[a] = $signed({ctr1[a][COORD_W-1], ctr1[a]}) - $signed({2'b00, half1[a]});
    assign hi_ext[a] = $signed({ctr1[a][COORD_W-1], ctr1[a]}) + $signed({2'b00, half1[a]});
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int a = 0; a < 3; a++) begin
        lo2[a] <= sat_corner(lo_ext[a]);
        hi2[a] <= sat_corner(hi_ext[a]);
      end
      mat2 <= mat1;
    end
  end

  // One lane per output axis.
  coord_t vmin [3];
  coord_t vmax [3];
  coord_t row_m [3][3];

  for (genvar r = 0; r < 3; r++) begin : g_lane
    assign row_m[r][0] = mat2[r][0];
    assign row_m[r][1] = mat2[r][1];
    assign row_m[r][2] = mat2[r][2];

    taabb_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk  (clk),
      .en   (lane_en),
      .lo   (lo2),
      .hi   (hi2),
      .m    (row_m[r]),
      .m3   (mat2[r][3]),
      .vmin (vmin[r]),
      .vmax (vmax[r])
    );
  end

  // Result stage: half extent is half the span, center is min plus half.
  logic [COORD_W:0]   span [3];
  logic [HALF_W-1:0]  half_c [3];
  coord_t             center_c [3];
  coord_t             ocenter [3];
  logic [HALF_W-1:0]  ohalf [3];

  for (genvar a = 0; a < 3; a++) begin : g_result
    assign span[a]     = {vmax[a][COORD_W-1], vmax[a]} - {vmin[a][COORD_W-1], vmin[a]};
    assign half_c[a]   = span[a][COORD_W-1:1];
    assign center_c[a] = vmin[a] + {1'b0, half_c[a]};
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      ocenter <= center_c;
      ohalf   <= half_c;
    end
  end

  assign m_axis_tvalid = vout;
  assign m_axis_tdata  = {3'b000, ohalf[2], ohalf[1], ohalf[0],
                          ocenter[2], ocenter[1], ocenter[0]};

`ifndef NO_ASSERTIONS
  // Operand selection must give ordered bounds on every axis.
  assert property (@(posedge clk) disable iff (rst)
    v5 |-> ($signed(vmin[0]) <= $signed(vmax[0])) &&
           ($signed(vmin[1]) <= $signed(vmax[1])) &&
           ($signed(vmin[2]) <= $signed(vmax[2])))
    else $error("lane bounds out of order");

  // Input is refused only when every stage is full and the output is stalled.
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> v1 && v2 && v3 && v4 && v5 && vout && !m_axis_tready)
    else $error("input stalled with a free stage");

  // A stalled result word keeps its stage occupied.
  assert property (@(posedge clk) disable iff (rst)
    vout && !m_axis_tready |=> vout)
    else $error("stalled result dropped");
`endif

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Testbench for transformed_aabb: boxes and affine matrices go in, and every result
// box is checked field by field against a predictor of the transform.
// Depends on taabb_pkg and the transformed_aabb RTL.
module tb;
  import taabb_pkg::*;

  localparam int FRAC = 16;
  localparam logic signed [79:0] WIDE_MAX = 80'sd2147483647;
  localparam logic signed [79:0] WIDE_MIN = -80'sd2147483648;
  localparam logic [31:0] ONE_Q       = 32'h0001_0000;
  localparam logic [31:0] MINUS_ONE_Q = 32'hFFFF_0000;
  localparam logic [31:0] POS_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MAX     = 32'h8000_0000;
  localparam logic [30:0] HALF_MAX    = 31'h7FFF_FFFF;
  localparam int NUM_RANDOM = 1050;

  // Input word, first field in the lowest bits (struct members run from high to low).
  typedef struct packed {
    logic [2:0]              pad;
    logic [5:0][63:0]        rows;    // row0 cols01, row0 cols23, ... row2 cols23
    logic [2:0][HALF_W-1:0]  half;    // x, y, z
    logic [2:0][COORD_W-1:0] center;  // x, y, z
  } box_word_t;

  // Result word, same packing rule.
  typedef struct packed {
    logic [2:0]              pad;
    logic [2:0][HALF_W-1:0]  half;
    logic [2:0][COORD_W-1:0] center;
  } bound_word_t;

  typedef enum int {STY_RAW, STY_MODERATE, STY_EXTREME} entry_style_t;

  // Predicts the bounding box of each accepted input and checks the results in order.
  class bound_scoreboard;
    bound_word_t pending[$];
    int errors;
    string axis_tag[3] = '{"x", "y", "z"};

    static function coord_t clamp_coord(input logic signed [79:0] v);
      logic signed [79:0] c;
      c = v;
      if (v > WIDE_MAX) c = WIDE_MAX;
      if (v < WIDE_MIN) c = WIDE_MIN;
      return c[31:0];
    endfunction

    // Transform all eight corners and keep per-axis min and max.
    function bound_word_t transform_box(input box_word_t w);
      logic signed [79:0] ctr [3];
      logic signed [79:0] hlf [3];
      logic signed [79:0] corner [3];
      logic signed [79:0] mat [3][4];
      logic signed [79:0] lo [3];
      logic signed [79:0] hi [3];
      logic signed [79:0] acc, v, span, mid;
      bound_word_t r;
      int a, c;
      r = '0;
      for (a = 0; a < 3; a++) begin
        ctr[a] = $signed(w.center[a]);
        hlf[a] = 80'(w.half[a]);
        mat[a][0] = $signed(w.rows[2*a][31:0]);
        mat[a][1] = $signed(w.rows[2*a][63:32]);
        mat[a][2] = $signed(w.rows[2*a+1][31:0]);
        mat[a][3] = $signed(w.rows[2*a+1][63:32]);
      end
      for (c = 0; c < 8; c++) begin
        for (a = 0; a < 3; a++) begin
          if (((c >> a) & 1) != 0) begin
            corner[a] = clamp_coord(ctr[a] + hlf[a]);
          end else begin
            corner[a] = clamp_coord(ctr[a] - hlf[a]);
          end
        end
        for (a = 0; a < 3; a++) begin
          acc = mat[a][0] * corner[0] + mat[a][1] * corner[1] + mat[a][2] * corner[2]
              + (mat[a][3] <<< FRAC);
          v = clamp_coord(acc >>> FRAC);
          if (c == 0 || v < lo[a]) lo[a] = v;
          if (c == 0 || v > hi[a]) hi[a] = v;
        end
      end
      for (a = 0; a < 3; a++) begin
        span = (hi[a] - lo[a]) >>> 1;
        mid = lo[a] + span;
        r.center[a] = mid[31:0];
        r.half[a] = span[30:0];
      end
      return r;
    endfunction

    function void note_box(input box_word_t w);
      pending.push_back(transform_box(w));
    endfunction

    function void flag(input string what, input logic [31:0] want, input logic [31:0] got);
      errors++;
      if (errors <= 10) $display("mismatch on %s: expected %h, got %h", what, want, got);
    endfunction

    function void check_box(input bound_word_t got);
      bound_word_t want;
      int a;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result word with nothing expected: %h", got);
        return;
      end
      want = pending.pop_front();
      for (a = 0; a < 3; a++) begin
        if (got.center[a] !== want.center[a]) begin
          flag({"out_center_", axis_tag[a]}, want.center[a], got.center[a]);
        end
        if (got.half[a] !== want.half[a]) begin
          flag({"out_half_", axis_tag[a]}, {1'b0, want.half[a]}, {1'b0, got.half[a]});
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  bound_scoreboard board = new();

  transformed_aabb #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watch both handshakes; values read here are the ones from before the edge.
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) board.note_box(s_axis_tdata);
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_box(m_axis_tdata);
  end

  // Half the time no gap, else a short or medium one, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [31:0] rand_entry(input entry_style_t st, input int unsigned span);
    logic [31:0] picks [6];
    picks = '{32'h0, ONE_Q, MINUS_ONE_Q, POS_MAX, NEG_MAX, 32'hFFFF_FFFF};
    case (st)
      STY_RAW: begin
        return $urandom;
      end
      STY_MODERATE: begin
        return $urandom_range(0, 2 * span) - span;
      end
      default: begin
        return picks[$urandom_range(0, 5)];
      end
    endcase
  endfunction

  function automatic entry_style_t style_for(input int kind);
    if (kind <= 1) return STY_RAW;
    if (kind <= 7) return STY_MODERATE;
    if (kind == 8) return entry_style_t'($urandom_range(0, 2));
    return STY_EXTREME;
  endfunction

  // Most boxes keep results in range; the rest push products and corners to saturation.
  function automatic box_word_t random_box();
    box_word_t w;
    entry_style_t st;
    logic [31:0] t;
    int kind, a, r;
    w = '0;
    kind = $urandom_range(0, 9);
    for (a = 0; a < 3; a++) begin
      w.center[a] = rand_entry(style_for(kind), 1 << 24);
      st = style_for(kind);
      if (st == STY_MODERATE) begin
        w.half[a] = 31'($urandom_range(0, 1 << 22));
      end else begin
        t = rand_entry(st, 0);
        w.half[a] = t[30:0];
      end
    end
    for (r = 0; r < 6; r++) begin
      w.rows[r] = {rand_entry(style_for(kind), (r % 2) ? (1 << 24) : (1 << 18)),
                   rand_entry(style_for(kind), 1 << 18)};
    end
    return w;
  endfunction

  function automatic box_word_t with_row(input box_word_t w, input int r,
                                         input logic [31:0] m0, input logic [31:0] m1,
                                         input logic [31:0] m2, input logic [31:0] m3);
    w.rows[2*r] = {m1, m0};
    w.rows[2*r+1] = {m3, m2};
    return w;
  endfunction

  // Box under the identity matrix.
  function automatic box_word_t plain_box(input logic [31:0] cx, input logic [31:0] cy,
                                          input logic [31:0] cz, input logic [30:0] hx,
                                          input logic [30:0] hy, input logic [30:0] hz);
    box_word_t w;
    w = '0;
    w.center[0] = cx;
    w.center[1] = cy;
    w.center[2] = cz;
    w.half[0] = hx;
    w.half[1] = hy;
    w.half[2] = hz;
    w = with_row(w, 0, ONE_Q, 32'h0, 32'h0, 32'h0);
    w = with_row(w, 1, 32'h0, ONE_Q, 32'h0, 32'h0);
    w = with_row(w, 2, 32'h0, 32'h0, ONE_Q, 32'h0);
    return w;
  endfunction

  function automatic box_word_t uniform_matrix(input box_word_t w, input logic [31:0] m);
    int r;
    for (r = 0; r < 3; r++) w = with_row(w, r, m, m, m, m);
    return w;
  endfunction

  task automatic send_box(input box_word_t w);
    int gap;
    gap = in_calm ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= w;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Waits for a clock edge before checking, so the word accepted at the current edge is already noted.
  task automatic wait_drained();
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    box_word_t w;
    box_word_t big;
    // Identity with an empty box, then the widest extent.
    send_box(plain_box(32'h0, 32'h0, 32'h0, 31'h0, 31'h0, 31'h0));
    send_box(plain_box(32'h0, 32'h0, 32'h0, HALF_MAX, HALF_MAX, HALF_MAX));
    // Corners that saturate at the top and at the bottom, then extreme centers with no extent.
    send_box(plain_box(POS_MAX, POS_MAX, POS_MAX, HALF_MAX, HALF_MAX, HALF_MAX));
    send_box(plain_box(NEG_MAX, NEG_MAX, NEG_MAX, HALF_MAX, HALF_MAX, HALF_MAX));
    send_box(plain_box(NEG_MAX, POS_MAX, 32'h0, 31'h0, 31'h0, 31'h0));
    // Mirror on every axis swaps min and max.
    w = plain_box(32'h0001_8000, 32'hFFFE_0000, 32'h0003_0000,
                  31'h0001_0000, 31'h0002_0000, 31'h0003_0000);
    w = with_row(w, 0, MINUS_ONE_Q, 32'h0, 32'h0, 32'h0);
    w = with_row(w, 1, 32'h0, MINUS_ONE_Q, 32'h0, 32'h0);
    w = with_row(w, 2, 32'h0, 32'h0, MINUS_ONE_Q, 32'h0);
    send_box(w);
    // Coordinate sums far outside the 32-bit range.
    big = plain_box(POS_MAX, NEG_MAX, POS_MAX, HALF_MAX, HALF_MAX, HALF_MAX);
    send_box(uniform_matrix(big, POS_MAX));
    send_box(uniform_matrix(big, NEG_MAX));
    send_box(uniform_matrix(plain_box(NEG_MAX, NEG_MAX, NEG_MAX, 31'h0, 31'h0, 31'h0),
                            NEG_MAX));
    // Translation only, at its extremes.
    w = uniform_matrix(plain_box(32'h1234_5678, 32'h0, 32'h0, 31'h100, 31'h0, 31'h0), 32'h0);
    w = with_row(w, 0, 32'h0, 32'h0, 32'h0, POS_MAX);
    w = with_row(w, 1, 32'h0, 32'h0, 32'h0, NEG_MAX);
    w = with_row(w, 2, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
    send_box(w);
    // Quarter turn about z: x' = -y + 1, y' = x - 1.
    w = plain_box(32'h0002_0000, 32'h0005_0000, 32'hFFFF_0000,
                  31'h0001_0000, 31'h0000_8000, 31'h0004_0000);
    w = with_row(w, 0, 32'h0, MINUS_ONE_Q, 32'h0, ONE_Q);
    w = with_row(w, 1, ONE_Q, 32'h0, 32'h0, MINUS_ONE_Q);
    send_box(w);
    // Tiny negative, then tiny positive entries make the floor visible.
    send_box(uniform_matrix(plain_box(32'h0003_0001, 32'hFFFF_FFFF, 32'h1,
                                      31'h5, 31'h1_0001, 31'h3), 32'hFFFF_FFFF));
    send_box(uniform_matrix(plain_box(32'h1, 32'h1, 32'h1, 31'h1, 31'h1, 31'h1), 32'h1));
    // Scale by two with a unit offset.
    w = plain_box(32'hFFF0_0000, 32'h0010_0000, 32'h0, 31'h0008_0000, 31'h0, 31'h7FFF_0000);
    w = with_row(w, 0, 32'h0002_0000, 32'h0, 32'h0, ONE_Q);
    w = with_row(w, 1, 32'h0, 32'h0002_0000, 32'h0, ONE_Q);
    w = with_row(w, 2, 32'h0, 32'h0, 32'h0002_0000, ONE_Q);
    send_box(w);
    // Degenerate box under a full random matrix.
    w = random_box();
    w.half = '0;
    send_box(w);
  endtask

  initial begin
    int i;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (i = 0; i < NUM_RANDOM; i++) begin
      if (i % 150 == 0) begin
        in_calm = ($urandom_range(0, 3) == 0);
        out_calm = ($urandom_range(0, 3) == 0);
      end
      // Hold off once until the pipeline is empty.
      if (i == NUM_RANDOM / 2) begin
        s_axis_tvalid <= 1'b0;
        wait_drained();
      end
      send_box(random_box());
    end
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Receiver: bursts of ready with random stalls between them.
  initial begin
    int run, stall;
    forever begin
      run = $urandom_range(1, 12);
      m_axis_tready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = out_calm ? 0 : idle_len();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Hang guard, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

[sim.f]
rtl/taabb_pkg.sv
rtl/taabb_lane.sv
rtl/transformed_aabb.sv
bench/tb.sv
